// ----- design/jsu_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package jsu_pkg;

    // Decoder phase
    typedef enum logic [3:0] {
        PH_IDLE   = 4'd0,
        PH_STR    = 4'd1,
        PH_ESC    = 4'd2,
        PH_HEX1   = 4'd3,
        PH_WANTBS = 4'd4,
        PH_WANTU  = 4'd5,
        PH_HEX2   = 4'd6
    } phase_t;

    // Result kinds
    typedef enum logic [3:0] {
        K_BYTE         = 4'd0,
        K_DONE         = 4'd1,
        K_EXP_STRING   = 4'd2,
        K_CONTROL      = 4'd3,
        K_TRUNC_ESC    = 4'd4,
        K_BAD_ESC      = 4'd5,
        K_TRUNC_UNI    = 4'd6,
        K_BAD_HEX      = 4'd7,
        K_NO_LOW       = 4'd8,
        K_BAD_LOW      = 4'd9,
        K_UNPAIRED_LOW = 4'd10,
        K_UNTERM       = 4'd11
    } kind_t;

    // Character codes
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;

    // Surrogate ranges, upper six bits of the code unit
    localparam logic [5:0] SURR_HIGH_TAG = 6'b110110;
    localparam logic [5:0] SURR_LOW_TAG  = 6'b110111;

    // Decoder state
    typedef struct packed {
        phase_t      phase;
        logic [15:0] hex_accum;
        logic [1:0]  hex_count;
        logic [9:0]  high_half;
    } state_t;

    localparam state_t STATE_RESET = '{
        phase:     PH_IDLE,
        hex_accum: 16'h0000,
        hex_count: 2'd0,
        high_half: 10'd0
    };

    // Results caused by one input byte: up to four bytes of one kind
    typedef struct packed {
        logic [2:0]      cnt;
        kind_t           kind;
        logic [3:0][7:0] bytes;
    } group_t;

    // Hex digit value; bit 4 flags a valid digit
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39)
            r = {1'b1, c[3:0]};
        else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
            r = {1'b1, c[3:0] + 4'd9};
        return r;
    endfunction

    // UTF-8 encoding of one code point
    function automatic group_t utf8_enc(input logic [20:0] cp);
        group_t g;
        g = '0;
        g.kind = K_BYTE;
        if (cp <= 21'h00007F) begin
            g.cnt      = 3'd1;
            g.bytes[0] = {1'b0, cp[6:0]};
        end
        else if (cp <= 21'h0007FF) begin
            g.cnt      = 3'd2;
            g.bytes[0] = {3'b110, cp[10:6]};
            g.bytes[1] = {2'b10, cp[5:0]};
        end
        else if (cp <= 21'h00FFFF) begin
            g.cnt      = 3'd3;
            g.bytes[0] = {4'b1110, cp[15:12]};
            g.bytes[1] = {2'b10, cp[11:6]};
            g.bytes[2] = {2'b10, cp[5:0]};
        end
        else begin
            g.cnt      = 3'd4;
            g.bytes[0] = {5'b11110, cp[20:18]};
            g.bytes[1] = {2'b10, cp[17:12]};
            g.bytes[2] = {2'b10, cp[11:6]};
            g.bytes[3] = {2'b10, cp[5:0]};
        end
        return g;
    endfunction

endpackage

`default_nettype wire

// ----- design/jsu_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Raw byte channel
interface jsu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_data;

    modport source (output valid, output in_byte, output end_of_data, input ready);
    modport sink   (input valid, input in_byte, input end_of_data, output ready);
endinterface

// Result channel
interface jsu_out_if;
    logic           valid;
    logic           ready;
    jsu_pkg::kind_t kind;
    logic [7:0]     out_byte;
    logic           last;

    modport source (output valid, output kind, output out_byte, output last, input ready);
    modport sink   (input valid, input kind, input out_byte, input last, output ready);
endinterface

`default_nettype wire

// ----- design/jsu_decode.sv -----
`timescale 1ns / 1ps
`default_nettype none

// One-byte step of the string decoder: next state and the result group
module jsu_decode (
    input  jsu_pkg::state_t st,
    input  logic [7:0]      in_byte,
    input  logic            end_of_data,
    output jsu_pkg::state_t st_next,
    output jsu_pkg::group_t grp
);
    import jsu_pkg::*;

    logic        do_fail;
    kind_t       fail_kind;
    logic        do_emit;
    logic [20:0] emit_cp;
    logic [4:0]  hv;
    logic [15:0] acc_shift;
    logic        hex_done;
    logic [10:0] plane;

    assign hv        = hex_val(in_byte);
    assign acc_shift = {st.hex_accum[11:0], hv[3:0]};
    assign hex_done  = (st.hex_count == 2'd3);
    assign plane     = {1'b0, st.high_half} + 11'd64;

    always_comb
    begin
        st_next   = st;
        grp       = '0;
        grp.kind  = K_BYTE;
        do_fail   = 1'b0;
        fail_kind = K_EXP_STRING;
        do_emit   = 1'b0;
        emit_cp   = '0;

        case (st.phase)
            PH_STR:
            begin
                if (end_of_data) begin
                    do_fail = 1'b1; fail_kind = K_UNTERM;
                end
                else if (in_byte == CH_QUOTE) begin
                    grp.cnt       = 3'd1;
                    grp.kind      = K_DONE;
                    st_next.phase = PH_IDLE;
                end
                else if (in_byte < CH_SPACE) begin
                    do_fail = 1'b1; fail_kind = K_CONTROL;
                end
                else if (in_byte == CH_BSLASH) begin
                    st_next.phase = PH_ESC;
                end
                else begin
                    grp.cnt      = 3'd1;
                    grp.bytes[0] = in_byte;
                end
            end

            PH_ESC:
            begin
                if (end_of_data) begin
                    do_fail = 1'b1; fail_kind = K_TRUNC_ESC;
                end
                else begin
                    st_next.phase = PH_STR;
                    grp.cnt       = 3'd1;
                    case (in_byte)
                        CH_QUOTE:  grp.bytes[0] = CH_QUOTE;
                        CH_BSLASH: grp.bytes[0] = CH_BSLASH;
                        CH_SLASH:  grp.bytes[0] = CH_SLASH;
                        CH_B:      grp.bytes[0] = CH_BS;
                        CH_F:      grp.bytes[0] = CH_FF;
                        CH_N:      grp.bytes[0] = CH_LF;
                        CH_R:      grp.bytes[0] = CH_CR;
                        CH_T:      grp.bytes[0] = CH_TAB;
                        CH_U:
                        begin
                            grp.cnt           = 3'd0;
                            st_next.phase     = PH_HEX1;
                            st_next.hex_accum = '0;
                            st_next.hex_count = '0;
                        end
                        default:
                        begin
                            do_fail = 1'b1; fail_kind = K_BAD_ESC;
                        end
                    endcase
                end
            end

            PH_HEX1, PH_HEX2:
            begin
                if (end_of_data) begin
                    do_fail = 1'b1; fail_kind = K_TRUNC_UNI;
                end
                else if (!hv[4]) begin
                    do_fail = 1'b1; fail_kind = K_BAD_HEX;
                end
                else if (!hex_done) begin
                    st_next.hex_accum = acc_shift;
                    st_next.hex_count = st.hex_count + 2'd1;
                end
                else begin
                    st_next.hex_accum = '0;
                    st_next.hex_count = '0;
                    if (st.phase == PH_HEX1) begin
                        // First code unit
                        if (acc_shift[15:10] == SURR_HIGH_TAG) begin
                            st_next.high_half = acc_shift[9:0];
                            st_next.phase     = PH_WANTBS;
                        end
                        else if (acc_shift[15:10] == SURR_LOW_TAG) begin
                            do_fail = 1'b1; fail_kind = K_UNPAIRED_LOW;
                        end
                        else begin
                            do_emit = 1'b1;
                            emit_cp = {5'd0, acc_shift};
                        end
                    end
                    else begin
                        // Low half of a surrogate pair
                        if (acc_shift[15:10] != SURR_LOW_TAG) begin
                            do_fail = 1'b1; fail_kind = K_BAD_LOW;
                        end
                        else begin
                            do_emit = 1'b1;
                            emit_cp = {plane, acc_shift[9:0]};
                        end
                    end
                end
            end

            PH_WANTBS:
            begin
                if (end_of_data || in_byte != CH_BSLASH) begin
                    do_fail = 1'b1; fail_kind = K_NO_LOW;
                end
                else
                    st_next.phase = PH_WANTU;
            end

            PH_WANTU:
            begin
                if (end_of_data || in_byte != CH_U) begin
                    do_fail = 1'b1; fail_kind = K_NO_LOW;
                end
                else begin
                    st_next.phase     = PH_HEX2;
                    st_next.hex_accum = '0;
                    st_next.hex_count = '0;
                end
            end

            default:
            begin
                // Idle, also for codes that never arise
                st_next.phase = PH_IDLE;
                if (end_of_data) begin
                    do_fail = 1'b1; fail_kind = K_EXP_STRING;
                end
                else if (in_byte inside {CH_SPACE, CH_TAB, CH_CR, CH_LF}) begin
                end
                else if (in_byte == CH_QUOTE)
                    st_next.phase = PH_STR;
                else begin
                    do_fail = 1'b1; fail_kind = K_EXP_STRING;
                end
            end
        endcase

        // Code point out as UTF-8
        if (do_emit) begin
            grp           = utf8_enc(emit_cp);
            st_next.phase = PH_STR;
        end

        // Any error: one result, back to idle
        if (do_fail) begin
            grp               = '0;
            grp.cnt           = 3'd1;
            grp.kind          = fail_kind;
            st_next.phase     = PH_IDLE;
            st_next.hex_accum = '0;
            st_next.hex_count = '0;
        end
    end

endmodule

`default_nettype wire

// ----- design/json_string_unescape_utf8_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

// JSON string unescaper to UTF-8. Raw bytes enter on din, one per transfer;
// set end_of_data to flag the end of input. Each input byte is decoded in the
// cycle it is taken and gives zero to four results, which leave on dout one per
// transfer, all of one kind, with last set on the final one. The block takes a
// byte every cycle while dout is ready and each byte yields at most one result;
// a byte that yields N results holds the output register for N transfers, and
// din takes the next byte in the cycle the final one of them goes out. Kinds
// other than byte carry out_byte 0; after done or any error the decoder idles.
module json_string_unescape_utf8_core (
    input  logic              clk,
    input  logic              rst_n,
    jsu_in_if.sink            din,
    jsu_out_if.source         dout
);
    import jsu_pkg::*;

    state_t     state_reg;
    state_t     state_next;
    group_t     grp_next;
    group_t     grp_reg;
    logic       grp_valid_reg;
    logic [1:0] idx_reg;

    logic       in_xfer;
    logic       out_xfer;
    logic       at_last;
    logic       drain_done;

    // Decode step
    jsu_decode u_decode (
        .st          (state_reg),
        .in_byte     (din.in_byte),
        .end_of_data (din.end_of_data),
        .st_next     (state_next),
        .grp         (grp_next)
    );

    // Handshakes
    assign at_last    = ({1'b0, idx_reg} + 3'd1) == grp_reg.cnt;
    assign out_xfer   = dout.valid && dout.ready;
    assign drain_done = out_xfer && at_last;
    assign din.ready  = !grp_valid_reg || drain_done;
    assign in_xfer    = din.valid && din.ready;

    // Decoder state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= STATE_RESET;
        else if (in_xfer)
            state_reg <= state_next;
    end

    // Result group control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            grp_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else if (in_xfer && grp_next.cnt != 3'd0) begin
            grp_valid_reg <= 1'b1;
            idx_reg       <= '0;
        end
        else if (drain_done) begin
            grp_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else if (out_xfer) begin
            idx_reg <= idx_reg + 2'd1;
        end
    end

    // Result group payload
    always_ff @(posedge clk)
    begin
        if (in_xfer && grp_next.cnt != 3'd0)
            grp_reg <= grp_next;
    end

    // Output
    assign dout.valid    = grp_valid_reg;
    assign dout.kind     = grp_reg.kind;
    assign dout.out_byte = grp_reg.bytes[idx_reg];
    assign dout.last     = at_last;

    // Checks
    a_grp_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        grp_valid_reg |-> (grp_reg.cnt != 3'd0 && grp_reg.cnt <= 3'd4))
        else $error("held result group is empty or oversized");

    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        grp_valid_reg |-> ({1'b0, idx_reg} < grp_reg.cnt))
        else $error("result index past group end");

    a_single_nonbyte: assert property (@(posedge clk) disable iff (!rst_n)
        (grp_valid_reg && grp_reg.kind != K_BYTE) |-> (grp_reg.cnt == 3'd1 && dout.out_byte == 8'h00))
        else $error("non-byte result not a single zero result");

    a_stall_holds_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (grp_valid_reg && !dout.ready) |=> (grp_valid_reg && $stable(idx_reg)))
        else $error("result index moved without a transfer");

endmodule

`default_nettype wire

// ----- tb/tb_json_string_unescape_utf8_core.sv -----
`timescale 1ns / 1ps

module tb_json_string_unescape_utf8_core;
    import jsu_pkg::*;

    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 6;
    localparam int DIRECTED_LEN  = 25;
    localparam int RANDOM_ITEMS  = 385;
    localparam int QUIET_LIMIT   = 4000;
    localparam int DRAIN_CYCLES  = 16;
    localparam int MAX_REPORTS   = 10;

    typedef struct packed {
        logic [7:0] data;
        logic       eod;
    } raw_item_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
        logic       last;
    } decoded_t;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_LIGHT,
        RX_HEAVY,
        RX_PERIODIC
    } rx_mode_t;

    logic clk = 1'b0;
    logic rst_n;

    jsu_in_if  din();
    jsu_out_if dout();

    json_string_unescape_utf8_core DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .din   (din),
        .dout  (dout)
    );

    always #(CLK_HALF) clk = ~clk;

    raw_item_t raw_bytes[$];
    decoded_t  expected_out[$];

    // Decoder shadow state
    phase_t      dec_phase = PH_IDLE;
    logic [15:0] hex_acc   = 16'h0000;
    logic [1:0]  hex_cnt   = 2'd0;
    logic [9:0]  hi_surr   = 10'd0;
    decoded_t    step_res[4];
    int          step_n;

    int        mismatches   = 0;
    int        burst_left   = 0;
    int        gap_left     = 0;
    int        quiet_cycles = 0;
    int        rx_left      = 0;
    int        rx_tick      = 0;
    rx_mode_t  rx_mode      = RX_OPEN;
    raw_item_t next_item;
    decoded_t  want;

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Bit 4 set when c is a hex digit
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [7:0] v;
        v = 8'hFF;
        if (c >= 8'h30 && c <= 8'h39)
            v = c - 8'h30;
        else if (c >= 8'h61 && c <= 8'h66)
            v = c - 8'h57;
        else if (c >= 8'h41 && c <= 8'h46)
            v = c - 8'h37;
        return {v != 8'hFF, v[3:0]};
    endfunction

    function automatic void add_result(input kind_t k, input logic [7:0] b);
        step_res[step_n] = '{kind: k, data: b, last: 1'b0};
        step_n++;
    endfunction

    function automatic void abort_string(input kind_t k);
        add_result(k, 8'h00);
        dec_phase = PH_IDLE;
        hex_acc   = 16'h0000;
        hex_cnt   = 2'd0;
    endfunction

    function automatic void emit_code_point(input logic [20:0] cp);
        if (cp <= 21'h7F) begin
            add_result(K_BYTE, cp[7:0]);
        end
        else if (cp <= 21'h7FF) begin
            add_result(K_BYTE, 8'hC0 | cp[10:6]);
            add_result(K_BYTE, 8'h80 | cp[5:0]);
        end
        else if (cp <= 21'hFFFF) begin
            add_result(K_BYTE, 8'hE0 | cp[15:12]);
            add_result(K_BYTE, 8'h80 | cp[11:6]);
            add_result(K_BYTE, 8'h80 | cp[5:0]);
        end
        else begin
            add_result(K_BYTE, 8'hF0 | cp[20:18]);
            add_result(K_BYTE, 8'h80 | cp[17:12]);
            add_result(K_BYTE, 8'h80 | cp[11:6]);
            add_result(K_BYTE, 8'h80 | cp[5:0]);
        end
        dec_phase = PH_STR;
    endfunction

    // Advance the shadow decoder by one accepted byte, queue what it yields
    function automatic void decode_item(input logic [7:0] c, input logic eod);
        logic [4:0]  d;
        logic [15:0] unit;
        step_n = 0;
        case (dec_phase)
            PH_STR: begin
                if (eod)
                    abort_string(K_UNTERM);
                else if (c == CH_QUOTE) begin
                    add_result(K_DONE, 8'h00);
                    dec_phase = PH_IDLE;
                end
                else if (c < CH_SPACE)
                    abort_string(K_CONTROL);
                else if (c == CH_BSLASH)
                    dec_phase = PH_ESC;
                else
                    add_result(K_BYTE, c);
            end
            PH_ESC: begin
                if (eod)
                    abort_string(K_TRUNC_ESC);
                else begin
                    dec_phase = PH_STR;
                    case (c)
                        CH_QUOTE, CH_BSLASH, CH_SLASH: add_result(K_BYTE, c);
                        CH_B: add_result(K_BYTE, CH_BS);
                        CH_F: add_result(K_BYTE, CH_FF);
                        CH_N: add_result(K_BYTE, CH_LF);
                        CH_R: add_result(K_BYTE, CH_CR);
                        CH_T: add_result(K_BYTE, CH_TAB);
                        CH_U: begin
                            dec_phase = PH_HEX1;
                            hex_acc   = 16'h0000;
                            hex_cnt   = 2'd0;
                        end
                        default: abort_string(K_BAD_ESC);
                    endcase
                end
            end
            PH_HEX1, PH_HEX2: begin
                d = hex_digit(c);
                if (eod)
                    abort_string(K_TRUNC_UNI);
                else if (!d[4])
                    abort_string(K_BAD_HEX);
                else begin
                    hex_acc = {hex_acc[11:0], d[3:0]};
                    if (hex_cnt != 2'd3)
                        hex_cnt = hex_cnt + 2'd1;
                    else begin
                        // four digits in: classify the code unit
                        hex_cnt = 2'd0;
                        unit    = hex_acc;
                        hex_acc = 16'h0000;
                        if (dec_phase == PH_HEX1) begin
                            if (unit[15:10] == SURR_HIGH_TAG) begin
                                hi_surr   = unit[9:0];
                                dec_phase = PH_WANTBS;
                            end
                            else if (unit[15:10] == SURR_LOW_TAG)
                                abort_string(K_UNPAIRED_LOW);
                            else
                                emit_code_point({5'd0, unit});
                        end
                        else if (unit[15:10] != SURR_LOW_TAG)
                            abort_string(K_BAD_LOW);
                        else
                            emit_code_point(21'h10000 + {1'b0, hi_surr, unit[9:0]});
                    end
                end
            end
            PH_WANTBS: begin
                if (eod || c != CH_BSLASH)
                    abort_string(K_NO_LOW);
                else
                    dec_phase = PH_WANTU;
            end
            PH_WANTU: begin
                if (eod || c != CH_U)
                    abort_string(K_NO_LOW);
                else begin
                    dec_phase = PH_HEX2;
                    hex_acc   = 16'h0000;
                    hex_cnt   = 2'd0;
                end
            end
            default: begin
                dec_phase = PH_IDLE;
                if (eod)
                    abort_string(K_EXP_STRING);
                else if (c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF) begin
                end
                else if (c == CH_QUOTE)
                    dec_phase = PH_STR;
                else
                    abort_string(K_EXP_STRING);
            end
        endcase
        for (int i = 0; i < step_n; i++) begin
            if (i == step_n - 1)
                step_res[i].last = 1'b1;
            expected_out = {expected_out, step_res[i]};
        end
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic void push_raw(input logic [7:0] d, input logic e);
        raw_item_t item;
        item      = '{data: d, eod: e};
        raw_bytes = {raw_bytes, item};
    endfunction

    // End of data carries a junk byte that must be ignored
    function automatic void push_eod();
        logic [7:0] junk;
        junk = 8'($urandom_range(0, 255));
        push_raw(junk, 1'b1);
    endfunction

    // Backslash, u, then the leading ndigits hex digits of u16, mixed case
    function automatic void push_escape_u(input logic [15:0] u16, input int ndigits);
        logic [3:0] nib;
        push_raw(CH_BSLASH, 1'b0);
        push_raw(CH_U, 1'b0);
        for (int i = 0; i < ndigits; i++) begin
            nib = u16[15 - 4 * i -: 4];
            if (nib < 4'd10)
                push_raw(8'h30 + nib, 1'b0);
            else
                push_raw(($urandom_range(0, 1) ? 8'h61 : 8'h41) + nib - 8'd10, 1'b0);
        end
    endfunction

    function automatic logic [15:0] rand_high();
        return 16'hD800 | 16'($urandom_range(0, 1023));
    endfunction

    function automatic logic [15:0] rand_low();
        return 16'hDC00 | 16'($urandom_range(0, 1023));
    endfunction

    // Non-surrogate BMP code unit, spread over the 1/2/3-byte encodings
    function automatic logic [15:0] rand_bmp();
        case ($urandom_range(0, 3))
            0:       return 16'($urandom_range(0, 16'h7F));
            1:       return 16'($urandom_range(16'h80, 16'h7FF));
            2:       return 16'($urandom_range(16'h800, 16'hD7FF));
            default: return 16'($urandom_range(16'hE000, 16'hFFFF));
        endcase
    endfunction

    function automatic logic [7:0] rand_non_hex();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (hex_digit(b) >= 5'h10);
        return b;
    endfunction

    function automatic logic [7:0] rand_bad_escape();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == CH_QUOTE || b == CH_BSLASH || b == CH_SLASH || b == CH_B ||
               b == CH_F || b == CH_N || b == CH_R || b == CH_T || b == CH_U);
        return b;
    endfunction

    function automatic logic [7:0] rand_other_than(input logic [7:0] avoid);
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == avoid);
        return b;
    endfunction

    function automatic logic [7:0] esc_letter(input int idx);
        case (idx)
            0:       return CH_QUOTE;
            1:       return CH_BSLASH;
            2:       return CH_SLASH;
            3:       return CH_B;
            4:       return CH_F;
            5:       return CH_N;
            6:       return CH_R;
            default: return CH_T;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Driver: bursts of transfers separated by random gaps
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            din.valid       <= 1'b0;
            din.in_byte     <= 8'h00;
            din.end_of_data <= 1'b0;
            burst_left      <= 0;
            gap_left        <= 0;
        end
        else begin
            if (din.valid && din.ready)
                decode_item(din.in_byte, din.end_of_data);
            if (!din.valid || din.ready) begin
                if (gap_left != 0) begin
                    gap_left  <= gap_left - 1;
                    din.valid <= 1'b0;
                end
                else if (raw_bytes.size() != 0) begin
                    next_item        = raw_bytes.pop_front();
                    din.valid       <= 1'b1;
                    din.in_byte     <= next_item.data;
                    din.end_of_data <= next_item.eod;
                    if (burst_left <= 1) begin
                        // long gapless stretch now and then
                        if ($urandom_range(0, 3) == 0) begin
                            burst_left <= 64;
                            gap_left   <= 0;
                        end
                        else begin
                            burst_left <= $urandom_range(1, 24);
                            gap_left   <= $urandom_range(1, 6);
                        end
                    end
                    else
                        burst_left <= burst_left - 1;
                end
                else
                    din.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver back-pressure, switching between stall modes
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            dout.ready <= 1'b0;
            rx_left    <= 0;
            rx_mode    <= RX_OPEN;
            rx_tick    <= 0;
        end
        else begin
            rx_tick <= rx_tick + 1;
            if (rx_left == 0) begin
                rx_mode <= rx_mode_t'($urandom_range(0, 3));
                rx_left <= $urandom_range(16, 160);
            end
            else
                rx_left <= rx_left - 1;
            case (rx_mode)
                RX_OPEN:  dout.ready <= 1'b1;
                RX_LIGHT: dout.ready <= ($urandom_range(0, 3) != 0);
                RX_HEAVY: dout.ready <= ($urandom_range(0, 3) == 0);
                default:  dout.ready <= ((rx_tick % 5) < 2);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compare each result transfer with the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (rst_n && dout.valid && dout.ready) begin
            if (expected_out.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result: kind %0d byte %02h last %0b",
                             dout.kind, dout.out_byte, dout.last);
            end
            else begin
                want = expected_out.pop_front();
                if (dout.kind !== want.kind || dout.out_byte !== want.data ||
                    dout.last !== want.last) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display({"mismatch: expected kind %0d byte %02h last %0b, ",
                                  "got kind %0d byte %02h last %0b"},
                                 want.kind, want.data, want.last,
                                 dout.kind, dout.out_byte, dout.last);
                end
            end
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge clk) begin
        if (rst_n) begin
            if ((din.valid && din.ready) || (dout.valid && dout.ready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= QUIET_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial begin
        int         nseg;
        int         pick;
        logic [7:0] b;

        rst_n           = 1'b0;
        din.valid       = 1'b0;
        din.in_byte     = 8'h00;
        din.end_of_data = 1'b0;
        dout.ready      = 1'b0;

        // Directed: junk and end of data while idle, extreme bytes, a simple
        // escape, encoded NUL, the highest pair, end of data inside a string
        push_raw(8'h00, 1'b0);
        push_eod();
        push_raw(CH_QUOTE, 1'b0);
        push_raw(8'hFF, 1'b0);
        push_raw(CH_BSLASH, 1'b0);
        push_raw(CH_N, 1'b0);
        push_escape_u(16'h0000, 4);
        push_escape_u(16'hDBFF, 4);
        push_escape_u(16'hDFFF, 4);
        push_eod();

        // Random: mostly well-formed strings, some broken, some idle noise
        while (raw_bytes.size() < DIRECTED_LEN + RANDOM_ITEMS) begin
            if ($urandom_range(0, 99) < 10) begin
                if ($urandom_range(0, 3) == 0)
                    push_eod();
                else
                    push_raw(rand_other_than(CH_QUOTE), 1'b0);
            end
            else begin
                repeat ($urandom_range(0, 2)) begin
                    case ($urandom_range(0, 3))
                        0:       push_raw(CH_SPACE, 1'b0);
                        1:       push_raw(CH_TAB, 1'b0);
                        2:       push_raw(CH_CR, 1'b0);
                        default: push_raw(CH_LF, 1'b0);
                    endcase
                end
                push_raw(CH_QUOTE, 1'b0);
                nseg = $urandom_range(0, 8);
                repeat (nseg) begin
                    pick = $urandom_range(0, 99);
                    if (pick < 40) begin
                        b = 8'($urandom_range(32, 255));
                        if (b == CH_QUOTE || b == CH_BSLASH)
                            b = 8'h7E;
                        push_raw(b, 1'b0);
                    end
                    else if (pick < 60) begin
                        push_raw(CH_BSLASH, 1'b0);
                        push_raw(esc_letter($urandom_range(0, 7)), 1'b0);
                    end
                    else if (pick < 85)
                        push_escape_u(rand_bmp(), 4);
                    else begin
                        push_escape_u(rand_high(), 4);
                        push_escape_u(rand_low(), 4);
                    end
                end

                // Close the string, or break it in one of many ways
                if ($urandom_range(0, 99) < 70)
                    push_raw(CH_QUOTE, 1'b0);
                else begin
                    case ($urandom_range(0, 10))
                        0: push_raw(8'($urandom_range(0, 31)), 1'b0);
                        1: push_eod();
                        2: begin
                            push_raw(CH_BSLASH, 1'b0);
                            push_eod();
                        end
                        3: begin
                            push_raw(CH_BSLASH, 1'b0);
                            push_raw(rand_bad_escape(), 1'b0);
                        end
                        4: begin
                            push_escape_u(rand_bmp(), $urandom_range(0, 3));
                            push_eod();
                        end
                        5: begin
                            push_escape_u(rand_bmp(), $urandom_range(0, 3));
                            push_raw(rand_non_hex(), 1'b0);
                        end
                        6: begin
                            push_escape_u(rand_high(), 4);
                            if ($urandom_range(0, 1))
                                push_eod();
                            else
                                push_raw(rand_other_than(CH_BSLASH), 1'b0);
                        end
                        7: begin
                            push_escape_u(rand_high(), 4);
                            push_raw(CH_BSLASH, 1'b0);
                            if ($urandom_range(0, 1))
                                push_eod();
                            else
                                push_raw(rand_other_than(CH_U), 1'b0);
                        end
                        8: begin
                            push_escape_u(rand_high(), 4);
                            push_escape_u($urandom_range(0, 1) ? rand_bmp() : rand_high(), 4);
                        end
                        9: push_escape_u(rand_low(), 4);
                        default: begin
                            push_escape_u(rand_high(), 4);
                            push_escape_u(rand_low(), $urandom_range(0, 3));
                            if ($urandom_range(0, 1))
                                push_eod();
                            else
                                push_raw(rand_non_hex(), 1'b0);
                        end
                    endcase
                end
            end
        end

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Drain: all bytes sent and every expected result seen
        while (raw_bytes.size() != 0 || din.valid || expected_out.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && expected_out.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
